// ===== rtl/core/mqtt_unsub_pkg.sv =====
`default_nettype none

package mqtt_unsub_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 28;
  localparam int unsigned IdW     = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned GroupW  = 7;

  localparam logic [KindW-1:0] KIND_ID    = 2'd0;
  localparam logic [KindW-1:0] KIND_BYTE  = 2'd1;
  localparam logic [KindW-1:0] KIND_EMPTY = 2'd2;
  localparam logic [KindW-1:0] KIND_END   = 2'd3;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_TOO_LONG = 2'd1;
  localparam logic [StatusW-1:0] ST_EARLY    = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ByteW-1:0]   header;
    logic [LenW-1:0]    rem_len;
    logic [IdW-1:0]     pkt_id;
    logic [ByteW-1:0]   tbyte;
    logic               tlast;
    logic               mlast;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mqtt_unsubscribe_packet_parser.sv =====
`default_nettype none

// channel   handshake              payload
// input     in_valid_i/in_ready_o  data_byte_i, end_of_message_i
// output    out_valid_o/out_ready_i result_kind_o .. status_o
//
// one byte is accepted per cycle unless the input stalls; its result, if
// any, shows up in the output register on the next cycle
// the parse state machine updates on the accepting edge, so throughput is
// one byte per cycle, limited by the single output register
// the input stalls only while a result sits in the output register and is
// not being taken
// reset clears the parse state to the fixed header phase and empties the
// output register

module mqtt_unsubscribe_packet_parser
  import mqtt_unsub_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ByteW-1:0]   data_byte_i,
  input  wire logic               end_of_message_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [KindW-1:0]        result_kind_o,
  output logic [ByteW-1:0]        header_byte_o,
  output logic [LenW-1:0]         remaining_length_o,
  output logic [IdW-1:0]          packet_id_o,
  output logic [ByteW-1:0]        topic_byte_o,
  output logic                    topic_last_o,
  output logic                    message_last_o,
  output logic [StatusW-1:0]      status_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_ID_HIGH,
    PH_ID_LOW,
    PH_TLEN_HIGH,
    PH_TLEN_LOW,
    PH_TOPIC,
    PH_DROP
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] header_q, header_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [1:0]       grp_q, grp_d;
  logic [ByteW-1:0] id_hi_q, id_hi_d;
  logic [IdW-1:0]   pkt_id_q, pkt_id_d;
  logic [ByteW-1:0] tlen_hi_q, tlen_hi_d;
  logic [IdW-1:0]   tleft_q, tleft_d;

  logic             out_valid_q;
  result_t          res_q;
  result_t          res_d;
  logic             emit;
  logic             in_fire;
  logic             eom;
  logic [LenW-1:0]  grp_val;
  logic [IdW-1:0]   tlen;
  logic             tlast;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign eom        = end_of_message_i;
  assign tlen       = {tlen_hi_q, data_byte_i};
  assign tlast      = (tleft_q <= IdW'(1));

  always_comb begin
    unique case (grp_q)
      2'd0:    grp_val = LenW'(data_byte_i[GroupW-1:0]);
      2'd1:    grp_val = LenW'(data_byte_i[GroupW-1:0]) << GroupW;
      2'd2:    grp_val = LenW'(data_byte_i[GroupW-1:0]) << (2 * GroupW);
      default: grp_val = LenW'(data_byte_i[GroupW-1:0]) << (3 * GroupW);
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    header_d  = header_q;
    len_d     = len_q;
    grp_d     = grp_q;
    id_hi_d   = id_hi_q;
    pkt_id_d  = pkt_id_q;
    tlen_hi_d = tlen_hi_q;
    tleft_d   = tleft_q;
    emit      = 1'b0;
    res_d.kind   = KIND_END;
    res_d.tbyte  = '0;
    res_d.tlast  = 1'b0;
    res_d.mlast  = 1'b1;
    res_d.status = ST_EARLY;
    unique case (phase_q)
      PH_HEADER: begin
        header_d = data_byte_i;
        len_d    = '0;
        grp_d    = '0;
        pkt_id_d = '0;
        if (eom) begin
          emit = 1'b1;
        end else begin
          phase_d = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        len_d = len_q + grp_val;
        if (eom) begin
          emit    = 1'b1;
          phase_d = PH_HEADER;
        end else if (!data_byte_i[ByteW-1]) begin
          phase_d = PH_ID_HIGH;
        end else if (grp_q == 2'd3) begin
          phase_d = PH_DROP;
        end else begin
          grp_d = grp_q + 2'd1;
        end
      end
      PH_ID_HIGH: begin
        id_hi_d = data_byte_i;
        if (eom) begin
          emit    = 1'b1;
          phase_d = PH_HEADER;
        end else begin
          phase_d = PH_ID_LOW;
        end
      end
      PH_ID_LOW: begin
        pkt_id_d     = {id_hi_q, data_byte_i};
        emit         = 1'b1;
        res_d.kind   = KIND_ID;
        res_d.mlast  = eom;
        res_d.status = ST_OK;
        phase_d      = eom ? PH_HEADER : PH_TLEN_HIGH;
      end
      PH_TLEN_HIGH: begin
        tlen_hi_d = data_byte_i;
        if (eom) begin
          emit    = 1'b1;
          phase_d = PH_HEADER;
        end else begin
          phase_d = PH_TLEN_LOW;
        end
      end
      PH_TLEN_LOW: begin
        if (tlen == '0) begin
          emit         = 1'b1;
          res_d.kind   = KIND_EMPTY;
          res_d.mlast  = eom;
          res_d.status = ST_OK;
          phase_d      = eom ? PH_HEADER : PH_TLEN_HIGH;
        end else if (eom) begin
          emit    = 1'b1;
          phase_d = PH_HEADER;
        end else begin
          tleft_d = tlen;
          phase_d = PH_TOPIC;
        end
      end
      PH_TOPIC: begin
        emit         = 1'b1;
        res_d.kind   = KIND_BYTE;
        res_d.tbyte  = data_byte_i;
        res_d.tlast  = tlast;
        res_d.mlast  = eom;
        res_d.status = (eom && !tlast) ? ST_EARLY : ST_OK;
        tleft_d      = tlast ? '0 : tleft_q - IdW'(1);
        if (eom) begin
          phase_d = PH_HEADER;
        end else begin
          phase_d = tlast ? PH_TLEN_HIGH : PH_TOPIC;
        end
      end
      default: begin
        if (grp_q == 2'd3) begin
          emit         = 1'b1;
          res_d.mlast  = eom;
          res_d.status = ST_TOO_LONG;
          grp_d        = '0;
        end
        if (eom) begin
          phase_d = PH_HEADER;
        end
      end
    endcase
    res_d.header  = header_d;
    res_d.rem_len = len_d;
    res_d.pkt_id  = pkt_id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      header_q    <= '0;
      len_q       <= '0;
      grp_q       <= '0;
      id_hi_q     <= '0;
      pkt_id_q    <= '0;
      tlen_hi_q   <= '0;
      tleft_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (in_fire) begin
        phase_q   <= phase_d;
        header_q  <= header_d;
        len_q     <= len_d;
        grp_q     <= grp_d;
        id_hi_q   <= id_hi_d;
        pkt_id_q  <= pkt_id_d;
        tlen_hi_q <= tlen_hi_d;
        tleft_q   <= tleft_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_fire && emit;
      end
      if (in_fire && emit) begin
        res_q <= res_d;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = res_q.kind;
  assign header_byte_o      = res_q.header;
  assign remaining_length_o = res_q.rem_len;
  assign packet_id_o        = res_q.pkt_id;
  assign topic_byte_o       = res_q.tbyte;
  assign topic_last_o       = res_q.tlast;
  assign message_last_o     = res_q.mlast;
  assign status_o           = res_q.status;

  a_eom_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && eom |=> phase_q == PH_HEADER)
    else $error("message end did not return to fixed header phase");

  a_topic_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_BYTE |-> !topic_last_o && topic_byte_o == '0)
    else $error("topic fields set on a non topic result");

  a_too_long_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_TOO_LONG |-> result_kind_o == KIND_END)
    else $error("length error on wrong result kind");

  a_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EARLY |-> message_last_o)
    else $error("early end without message end");

endmodule

`default_nettype wire
